### hw/rtl/prs_pkg.sv
// Shared types and constants for the pattern replace stream unit.
// No dependencies; used by prs_cell and pattern_replace_stream_unit.
`default_nettype none

package prs_pkg;

  // One string byte
  typedef logic [7:0] byte_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PATTERN_BYTES      = 2'd0,
    CFG_PATTERN_LENGTH     = 2'd1,
    CFG_REPLACEMENT_BYTES  = 2'd2,
    CFG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_t;

  // Bytes held in each 64-bit packed register
  localparam int PACKED_BYTES = 8;

  // Replacement bytes above ASCII_MAX go out as SUB_CHAR ('?')
  localparam byte_t ASCII_MAX = 8'h7F;
  localparam byte_t SUB_CHAR  = 8'h3F;

  // Per-cycle command to every window cell
  typedef struct packed {
    logic shift;  // take the byte from the next cell up
    logic load;   // take the incoming string byte
  } cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/pattern_replace_stream_unit.sv
// Streaming find-and-replace: window of byte cells, step control and result register.
// An accepted byte sets the step control registers; its results then go out through the result register.
// Throughput: one byte per cycle while each byte gives at most one result and out_ready holds; a byte
// giving n results holds input until its last result is emitted, as results leave one per cycle from the register.
// After the last byte, the bytes left in the window go out, then the end marker.
// Reset (rst, synchronous): empties the window, clears pending work, registers and output.
// Depends on prs_pkg and prs_cell.
`default_nettype none

module pattern_replace_stream_unit #(
  parameter int PATTERN_MAX     = 8,
  parameter int REPLACEMENT_MAX = 8
) (
  input  wire                 clk,
  input  wire                 rst,
  // configuration write channel
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [1:0]          cfg_index,
  input  wire  [63:0]         cfg_data,
  // input byte channel
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [7:0]          in_byte,
  input  wire                 in_last,
  // result channel
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [7:0]          out_byte,
  output logic                byte_valid,
  output logic                string_end
);

  localparam int CW  = $clog2(PATTERN_MAX + 1);
  localparam int RW  = $clog2(REPLACEMENT_MAX + 1);
  localparam int RIW = (REPLACEMENT_MAX > 1) ? $clog2(REPLACEMENT_MAX) : 1;

  // Configuration registers
  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [63:0] replacement_bytes;
  logic [3:0]  replacement_length;

  // Step control registers
  logic [CW-1:0]  window_count, window_count_next;
  logic [1:0]     pop_left, pop_left_next;
  logic [RW-1:0]  rep_left, rep_left_next;
  logic [RIW-1:0] rep_idx, rep_idx_next;
  logic           flush, flush_next;

  // Result register
  logic           out_valid_next;
  prs_pkg::byte_t out_byte_next;
  logic           byte_valid_next;
  logic           string_end_next;

  // Working signals
  logic [CW-1:0] plen;
  logic [RW-1:0] rlen;
  logic          busy, can_load, emit, pop_now, last_unit, accept;
  logic [CW-1:0] cnt_sh, cnt_app, wr_pos;
  logic          full, over, eq, hit;
  logic [PATTERN_MAX-1:0] hit_raw, hit_ok;
  prs_pkg::byte_t rep_byte;

  prs_pkg::byte_t    win     [PATTERN_MAX];
  prs_pkg::byte_t    pat_tab [PATTERN_MAX];
  prs_pkg::byte_t    rep_tab [REPLACEMENT_MAX];
  prs_pkg::cell_ctl_t ctl    [PATTERN_MAX];

  assign cfg_ready = 1'b1;

  // Take configuration beats
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= '0;
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (prs_pkg::cfg_reg_t'(cfg_index))
        prs_pkg::CFG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        prs_pkg::CFG_PATTERN_LENGTH:     pattern_length     <= cfg_data[3:0];
        prs_pkg::CFG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        prs_pkg::CFG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[3:0];
      endcase
    end
  end

  // Saturate lengths to the window and replacement sizes
  always_comb begin
    if ({1'b0, pattern_length} > 5'(PATTERN_MAX)) begin
      plen = CW'(PATTERN_MAX);
    end else begin
      plen = CW'(pattern_length);
    end
    if ({1'b0, replacement_length} > 5'(REPLACEMENT_MAX)) begin
      rlen = RW'(REPLACEMENT_MAX);
    end else begin
      rlen = RW'(replacement_length);
    end
  end

  // Replacement byte table; positions past the packed register read as zero
  for (genvar r = 0; r < REPLACEMENT_MAX; r++) begin : g_rep
    if (r < prs_pkg::PACKED_BYTES) begin : g_packed
      assign rep_tab[r] = replacement_bytes[8*r +: 8];
    end else begin : g_zero
      assign rep_tab[r] = '0;
    end
  end

  assign rep_byte = (rep_tab[rep_idx] > prs_pkg::ASCII_MAX) ? prs_pkg::SUB_CHAR
                                                            : rep_tab[rep_idx];

  // Emission and input handshake
  always_comb begin
    busy      = (pop_left != '0) || (rep_left != '0) || flush;
    can_load  = !out_valid || out_ready;
    emit      = busy && can_load;
    pop_now   = emit && ((pop_left != '0) ||
                         ((rep_left == '0) && flush && (window_count != '0)));
    last_unit = emit && (((pop_left == 2'd1) && (rep_left == '0) && !flush) ||
                         ((pop_left == '0) && (rep_left == RW'(1)) && !flush) ||
                         ((pop_left == '0) && (rep_left == '0) && flush &&
                          (window_count == '0)));
    in_ready  = !busy || last_unit;
    accept    = in_valid && in_ready;
  end

  // Place the new byte behind whatever the window holds after this beat's shift
  always_comb begin
    cnt_sh  = pop_now ? (window_count - CW'(1)) : window_count;
    full    = (cnt_sh == CW'(PATTERN_MAX));
    cnt_app = full ? cnt_sh : (cnt_sh + CW'(1));
    wr_pos  = full ? CW'(PATTERN_MAX - 1) : cnt_sh;
  end

  // Row of window cells
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    prs_pkg::byte_t nb;

    if (i < prs_pkg::PACKED_BYTES) begin : g_pat
      assign pat_tab[i] = pattern_bytes[8*i +: 8];
    end else begin : g_pat_zero
      assign pat_tab[i] = '0;
    end

    if (i < PATTERN_MAX - 1) begin : g_nb
      assign nb = win[i+1];
    end else begin : g_nb_end
      assign nb = '0;
    end

    assign ctl[i].shift = pop_now;
    assign ctl[i].load  = accept && (wr_pos == CW'(i));

    prs_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .in_byte  (in_byte),
      .nb_byte  (nb),
      .pat_byte (pat_tab[i]),
      .data     (win[i]),
      .hit      (hit_raw[i])
    );

    // Positions past the pattern length do not take part
    assign hit_ok[i] = hit_raw[i] || (CW'(i) >= plen);
  end

  // Decide the step for the accepted byte
  always_comb begin
    over = (cnt_app > plen);
    eq   = (plen != '0) && (cnt_app == plen);
    hit  = eq && (&hit_ok);
  end

  // Next state: emit one result, then load a new step on an accepted beat
  always_comb begin
    window_count_next = window_count;
    pop_left_next     = pop_left;
    rep_left_next     = rep_left;
    rep_idx_next      = rep_idx;
    flush_next        = flush;
    out_byte_next     = out_byte;
    byte_valid_next   = byte_valid;
    string_end_next   = string_end;
    out_valid_next    = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid);

    if (emit) begin
      if (pop_left != '0) begin
        out_byte_next     = win[0];
        byte_valid_next   = 1'b1;
        string_end_next   = 1'b0;
        pop_left_next     = pop_left - 2'd1;
        window_count_next = window_count - CW'(1);
      end else if (rep_left != '0) begin
        out_byte_next   = rep_byte;
        byte_valid_next = 1'b1;
        string_end_next = 1'b0;
        rep_left_next   = rep_left - RW'(1);
        rep_idx_next    = rep_idx + RIW'(1);
      end else if (window_count != '0) begin
        out_byte_next     = win[0];
        byte_valid_next   = 1'b1;
        string_end_next   = 1'b0;
        window_count_next = window_count - CW'(1);
      end else begin
        out_byte_next   = '0;
        byte_valid_next = 1'b0;
        string_end_next = 1'b1;
        flush_next      = 1'b0;
      end
    end

    if (accept) begin
      if (over) begin
        pop_left_next = (cnt_app > CW'(1)) ? 2'd2 : 2'd1;
      end else if (eq && !hit) begin
        pop_left_next = 2'd1;
      end else begin
        pop_left_next = 2'd0;
      end
      rep_left_next     = hit ? rlen : '0;
      rep_idx_next      = '0;
      flush_next        = in_last;
      window_count_next = hit ? '0 : cnt_app;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      pop_left     <= '0;
      rep_left     <= '0;
      rep_idx      <= '0;
      flush        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      window_count <= window_count_next;
      pop_left     <= pop_left_next;
      rep_left     <= rep_left_next;
      rep_idx      <= rep_idx_next;
      flush        <= flush_next;
      out_valid    <= out_valid_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_byte   <= out_byte_next;
    byte_valid <= byte_valid_next;
    string_end <= string_end_next;
  end

endmodule

`default_nettype wire

### hw/rtl/prs_cell.sv
// One window cell: holds a byte, shifts towards the front, compares with its pattern byte.
// Depends on prs_pkg.
`default_nettype none

module prs_cell (
  input  wire                clk,
  input  prs_pkg::cell_ctl_t ctl,
  input  prs_pkg::byte_t     in_byte,
  input  prs_pkg::byte_t     nb_byte,
  input  prs_pkg::byte_t     pat_byte,
  output prs_pkg::byte_t     data,
  output logic               hit
);

  prs_pkg::byte_t data_next;

  // Load the new byte, else take the neighbour's byte on a shift, else hold
  always_comb begin
    if (ctl.load) begin
      data_next = in_byte;
    end else if (ctl.shift) begin
      data_next = nb_byte;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Compare the value this cell will hold after the current beat
  assign hit = (data_next == pat_byte);

endmodule

`default_nettype wire

### tb/sv/pattern_replace_stream_unit_tb.sv
// Self-checking testbench for pattern_replace_stream_unit: byte beats in, checked result beats out.
// Depends on prs_pkg and the unit's RTL; holds its own predictor of the replace window.
`timescale 1ns / 100ps

module pattern_replace_stream_unit_tb;

  localparam int WIN_DEPTH     = 8;
  localparam int REPL_DEPTH    = 8;
  localparam int RANDOM_ITEMS  = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;

  // One expected result beat
  typedef struct packed {
    prs_pkg::byte_t data;
    logic           is_byte;
    logic           is_end;
  } result_t;

  // Replace predictor and store of owed result beats
  class replace_scoreboard;
    logic [63:0]    pat_bytes = '0;
    logic [3:0]     pat_len   = '0;
    logic [63:0]    rep_bytes = '0;
    logic [3:0]     rep_len   = '0;
    prs_pkg::byte_t win[WIN_DEPTH];
    int unsigned    win_cnt = 0;
    result_t        owed_q[$];
    int errors       = 0;
    int bytes_in     = 0;
    int results_seen = 0;
    int hits         = 0;
    int strings      = 0;
    int settings     = 0;

    function int pending();
      return owed_q.size();
    endfunction

    function void note_config(prs_pkg::cfg_reg_t idx, logic [63:0] d);
      case (idx)
        prs_pkg::CFG_PATTERN_BYTES:      pat_bytes = d;
        prs_pkg::CFG_PATTERN_LENGTH:     pat_len   = d[3:0];
        prs_pkg::CFG_REPLACEMENT_BYTES:  rep_bytes = d;
        prs_pkg::CFG_REPLACEMENT_LENGTH: rep_len   = d[3:0];
        default: ;
      endcase
    endfunction

    function void owe_byte(prs_pkg::byte_t b);
      owed_q.push_back('{data: b, is_byte: 1'b1, is_end: 1'b0});
    endfunction

    // Drop the k oldest window bytes
    function void drop_oldest(int unsigned k);
      if (k >= win_cnt) begin
        win_cnt = 0;
        return;
      end
      for (int i = 0; i + k < win_cnt; i++) win[i] = win[i + k];
      win_cnt -= k;
    endfunction

    // Work out the result beats that one accepted byte causes
    function void note_input(prs_pkg::byte_t b, logic last);
      int unsigned plen, rlen, k;
      bit hit;
      prs_pkg::byte_t r;
      bytes_in++;
      plen = (pat_len > WIN_DEPTH) ? WIN_DEPTH : pat_len;
      rlen = (rep_len > REPL_DEPTH) ? REPL_DEPTH : rep_len;
      if (win_cnt < WIN_DEPTH) begin
        win[win_cnt] = b;
        win_cnt++;
      end else begin
        win[WIN_DEPTH - 1] = b;
      end
      if (win_cnt > plen) begin
        // window overfull: drain the two oldest, or the one byte when only one is held
        k = (win_cnt >= 2) ? 2 : 1;
        for (int i = 0; i < k; i++) owe_byte(win[i]);
        drop_oldest(k);
      end else if (plen > 0 && win_cnt == plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++)
          if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          hits++;
          for (int i = 0; i < rlen; i++) begin
            r = rep_bytes[8*i +: 8];
            owe_byte((r > prs_pkg::ASCII_MAX) ? prs_pkg::SUB_CHAR : r);
          end
          win_cnt = 0;
        end else begin
          owe_byte(win[0]);
          drop_oldest(1);
        end
      end
      if (last) begin
        // flush the window, then the end marker
        for (int i = 0; i < win_cnt; i++) owe_byte(win[i]);
        win_cnt = 0;
        owed_q.push_back('{data: 8'h00, is_byte: 1'b0, is_end: 1'b1});
        strings++;
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(prs_pkg::byte_t b, logic v, logic e);
      result_t want;
      results_seen++;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte %02h valid %0b end %0b", b, v, e));
        return;
      end
      want = owed_q.pop_front();
      if (b !== want.data)
        report_mismatch($sformatf("beat %0d out_byte %02h, want %02h",
                                  results_seen, b, want.data));
      if (v !== want.is_byte)
        report_mismatch($sformatf("beat %0d byte_valid %0b, want %0b",
                                  results_seen, v, want.is_byte));
      if (e !== want.is_end)
        report_mismatch($sformatf("beat %0d string_end %0b, want %0b",
                                  results_seen, e, want.is_end));
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        cfg_valid  = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [63:0] cfg_data   = '0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_byte    = '0;
  logic        in_last    = 1'b0;
  logic        out_ready  = 1'b0;
  wire         cfg_ready;
  wire         in_ready;
  wire         out_valid;
  wire  [7:0]  out_byte;
  wire         byte_valid;
  wire         string_end;

  replace_scoreboard sb = new();

  logic [63:0] cur_pat  = '0;
  logic [3:0]  cur_plen = '0;
  bit tx_quiet      = 1'b0;
  bit rx_quiet      = 1'b0;
  bit hold_off_req  = 1'b0;
  bit hold_off_done = 1'b0;
  int idle_cycles   = 0;

  pattern_replace_stream_unit #(
    .PATTERN_MAX     (WIN_DEPTH),
    .REPLACEMENT_MAX (REPL_DEPTH)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .string_end (string_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_byte, byte_valid, string_end);
  end

  // Abort when no channel moves a beat for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results owed",
                 idle_cycles, sb.pending());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin : receiver
    int unsigned stall;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(0, 7);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one byte beat after a random gap and hold it until taken
  task automatic send_beat(prs_pkg::byte_t b, logic last);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b, last);
  endtask

  task automatic write_reg(prs_pkg::cfg_reg_t idx, logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, d);
  endtask

  // Write all four registers; length writes carry junk in the unused bits
  task automatic write_settings(logic [63:0] pb, logic [3:0] pl,
                                logic [63:0] rb, logic [3:0] rl);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(prs_pkg::CFG_PATTERN_BYTES, pb);
    write_reg(prs_pkg::CFG_PATTERN_LENGTH, {junk[63:4], pl});
    write_reg(prs_pkg::CFG_REPLACEMENT_BYTES, rb);
    write_reg(prs_pkg::CFG_REPLACEMENT_LENGTH, {~junk[63:4], rl});
    cfg_valid <= 1'b0;
    cur_pat  = pb;
    cur_plen = pl;
    sb.settings++;
  endtask

  // Drop input valid and wait until the unit has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_list(prs_pkg::byte_t text[$], bit close);
    foreach (text[i]) send_beat(text[i], close && (i == text.size() - 1));
  endtask

  // Build a string of pattern copies, near misses and noise, then send it
  task automatic send_text(int chunks, bit close);
    prs_pkg::byte_t text[$];
    int unsigned plen, sel, n, pos;
    plen = (cur_plen > WIN_DEPTH) ? WIN_DEPTH : cur_plen;
    for (int c = 0; c < chunks; c++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4 && plen > 0) begin
        for (int j = 0; j < plen; j++) text.push_back(cur_pat[8*j +: 8]);
      end else if (sel < 6 && plen > 1) begin
        n = $urandom_range(1, plen - 1);
        for (int j = 0; j < n; j++) text.push_back(cur_pat[8*j +: 8]);
        text.push_back(8'($urandom));
      end else begin
        n = $urandom_range(1, 3);
        for (int j = 0; j < n; j++) begin
          if (plen > 0 && $urandom_range(0, 1)) begin
            pos = $urandom_range(0, plen - 1);
            text.push_back(cur_pat[8*pos +: 8]);
          end else begin
            text.push_back(8'($urandom));
          end
        end
      end
    end
    send_list(text, close);
  endtask

  initial begin : stimulus
    logic [63:0] pb, rb;
    logic [3:0]  pl, rl;
    int directed_count, nstr, phase;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings pass bytes through untouched
    send_list('{8'h00, 8'hFF}, 1'b1);

    // Two-byte pattern, replacement with a byte above ASCII
    settle();
    write_settings(64'h6261, 4'd2, 64'h59C158, 4'd3);
    send_list('{8'h61, 8'h61, 8'h62, 8'h61, 8'h62, 8'h63}, 1'b1);

    // Empty replacement deletes each hit
    settle();
    write_settings(64'h6261, 4'd2, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    send_list('{8'h78, 8'h61, 8'h62, 8'h79}, 1'b1);

    // Oversized lengths saturate; full eight-byte hit at end of string
    settle();
    write_settings(64'hFF00_A55A_0FF0_0180, 4'd12, 64'h0080_7FFF_4142_4300, 4'd15);
    send_list('{8'h80, 8'h01, 8'hF0, 8'h0F, 8'h5A, 8'hA5, 8'h00, 8'hFF}, 1'b1);

    // Lower the pattern length mid-string so the window drains
    send_list('{8'h80, 8'h01, 8'hF0, 8'h0F, 8'h5A}, 1'b0);
    settle();
    write_settings(64'hFF00_A55A_0FF0_0180, 4'd1, 64'h0080_7FFF_4142_4300, 4'd8);
    send_list('{8'h33, 8'h80}, 1'b1);
    directed_count = sb.bytes_in;

    // Random phases: fresh settings, a few strings each
    phase = 0;
    while (sb.bytes_in < directed_count + RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 5))
        0:       pl = 4'd0;
        1:       pl = 4'd1;
        2:       pl = 4'($urandom_range(2, 4));
        3:       pl = 4'd8;
        4:       pl = 4'($urandom_range(9, 15));
        default: pl = 4'($urandom_range(0, 15));
      endcase
      if ($urandom_range(0, 2) == 0) begin
        pb = {$urandom, $urandom};
      end else begin
        // small alphabet so hits and near misses are common
        for (int j = 0; j < 8; j++)
          case ($urandom_range(0, 3))
            0:       pb[8*j +: 8] = 8'h61;
            1:       pb[8*j +: 8] = 8'h62;
            2:       pb[8*j +: 8] = 8'h00;
            default: pb[8*j +: 8] = 8'hFF;
          endcase
      end
      case ($urandom_range(0, 3))
        0:       rl = 4'd0;
        1:       rl = 4'd8;
        2:       rl = 4'($urandom_range(9, 15));
        default: rl = 4'($urandom_range(1, 7));
      endcase
      rb = {$urandom, $urandom};
      if ($urandom_range(0, 1)) rb &= 64'h7F7F_7F7F_7F7F_7F7F;
      write_settings(pb, pl, rb, rl);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      nstr = $urandom_range(1, 3);
      if (phase == 2) begin
        // enough strings that the unit fills while the receiver holds off
        tx_quiet = 1'b1;
        hold_off_req = 1'b1;
        nstr = 3;
      end
      for (int s = 0; s < nstr; s++)
        send_text($urandom_range(1, 4), !(s == nstr - 1 && $urandom_range(0, 4) == 0));
      phase++;
    end

    // Close any open string, then drain
    tx_quiet = 1'b0;
    send_beat(8'($urandom), 1'b1);
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch($sformatf("%0d results never came", sb.pending()));

    $display("summary: %0d byte beats in %0d strings over %0d register settings, %0d hits",
             sb.bytes_in, sb.strings, sb.settings, sb.hits);
    $display("summary: %0d result beats checked, %0d mismatches",
             sb.results_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/prs_pkg.sv
hw/rtl/prs_cell.sv
hw/rtl/pattern_replace_stream_unit.sv
tb/sv/pattern_replace_stream_unit_tb.sv
